FILE: hw/rtl/asp_pkg.sv
// Shared types and constants for the ADC scan pulse counter.
// No dependencies; imported by every module of the block.
package asp_pkg;

   // Fixed field widths of the ports and registers.
   localparam int CH_PORT_BITS = 5;
   localparam int MASK_BITS    = 22;
   localparam int THR_BITS     = 12;
   localparam int BOUND_BITS   = 5;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values.
   localparam logic [MASK_BITS-1:0]  MASK_RESET  = '0;
   localparam logic [THR_BITS-1:0]   THR_RESET   = 12'd2000;
   localparam logic [BOUND_BITS-1:0] BOUND_RESET = 5'd11;

   // Word command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_EDGE   = 1'b1;

   // Register indexes, taken from byte address bits [3:2].
   typedef enum logic [1:0] {
      REG_PULSE_MODE = 2'd0,
      REG_DROP_THR   = 2'd1,
      REG_EDGE_BOUND = 2'd2
   } reg_index_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [MASK_BITS-1:0]  pulse_mode_mask;
      logic [THR_BITS-1:0]   drop_threshold;
      logic [BOUND_BITS-1:0] edge_counted_channels;
   } cfg_type;

endpackage

FILE: hw/rtl/adc_scan_pulse_counter.sv
// Top level of the ADC scan pulse counter: control, datapath and output word.
// Depends on asp_pkg, asp_csr, asp_scan and asp_store.
//
//   Port group | Direction | Handshake            | Moves
//   req_*      | in        | req_valid/req_stall  | sample or pin-edge word
//   rsp_*      | out       | rsp_valid/rsp_stall  | channel update word
//   psel...    | in/out    | APB setup + access   | configuration registers
//
// For each word the accept cycle reads the channel's entry from the state
// memory; the update state (ST_EXEC) then updates it and writes it back.
// A new word is accepted only after the previous word's update, one at a time.
// Reset is synchronous; the state memory needs no clearing pass, valid bits
// give the reset contents at once.
// A stalled result holds the update cycle until the output register frees up.
module adc_scan_pulse_counter #(
   parameter int NUM_CHANNELS = 22,
   parameter int SAMPLE_BITS  = 12,
   parameter int COUNT_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   input  logic [asp_pkg::CH_PORT_BITS-1:0]  req_edge_channel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [asp_pkg::CH_PORT_BITS-1:0]  rsp_channel,
   output logic [SAMPLE_BITS-1:0]            rsp_sample_out,
   output logic [COUNT_BITS-1:0]             rsp_pulse_count,
   output logic                              rsp_changed,
   output logic [asp_pkg::CH_PORT_BITS-1:0]  rsp_next_channel,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [asp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [asp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [asp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import asp_pkg::*;

   localparam int CH_W  = $clog2(NUM_CHANNELS);
   localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [CH_W-1:0] cur_ff, cur_in;

   // Captured word.
   logic                    cmd_ff;
   logic [SAMPLE_BITS-1:0]  smp_ff;
   logic [CH_PORT_BITS-1:0] ech_ff;
   logic [CH_W-1:0]         ch_ff;
   logic                    ech_ok_ff;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CH_PORT_BITS-1:0] rsp_channel_ff, rsp_channel_in;
   logic [SAMPLE_BITS-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic                    rsp_changed_ff, rsp_changed_in;
   logic [CH_PORT_BITS-1:0] rsp_next_ff, rsp_next_in;

   logic            accept;
   logic            exec_go;
   logic            ech_ok;
   logic [CH_W-1:0] rd_addr;
   logic [SAMPLE_BITS-1:0] rd_last;
   logic [COUNT_BITS-1:0]  rd_count;
   logic                   rd_flag;
   logic                   wr_en;
   logic [SAMPLE_BITS-1:0] wr_last;
   logic [COUNT_BITS-1:0]  wr_count;
   logic                   wr_flag;
   logic [CH_W-1:0]        scan_next;
   logic [31:0]            mask_wide;
   logic                   sample_tracked;
   logic [SAMPLE_BITS-1:0] drop;
   logic                   do_count;

   asp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   asp_scan #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_scan (
      .cfg          (cfg),
      .cur_channel  (ch_ff),
      .next_channel (scan_next)
   );

   asp_store #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .rd_last  (rd_last),
      .rd_count (rd_count),
      .rd_flag  (rd_flag),
      .wr_en    (wr_en),
      .wr_addr  (ch_ff),
      .wr_last  (wr_last),
      .wr_count (wr_count),
      .wr_flag  (wr_flag)
   );

   // Handshakes: one word in flight, update waits for a free output register.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Channel whose entry the word touches; an out-of-range edge reads entry zero.
   assign ech_ok  = 32'(req_edge_channel) < NUM_CHANNELS;
   always_comb begin
      if (req_cmd == CMD_EDGE) begin
         rd_addr = ech_ok ? req_edge_channel[CH_W-1:0] : '0;
      end else begin
         rd_addr = cur_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept)  state_in = ST_EXEC;
         ST_EXEC: if (exec_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Pulse detection on a tracked sample channel.
   assign mask_wide      = 32'(cfg.pulse_mode_mask);
   assign sample_tracked = mask_wide[5'(ch_ff)] &&
                           ({1'b0, CH_PORT_BITS'(ch_ff)} >=
                            {1'b0, cfg.edge_counted_channels});
   assign drop     = rd_last - smp_ff;
   assign do_count = sample_tracked && (rd_last > smp_ff) &&
                     (CMP_W'(drop) > CMP_W'(cfg.drop_threshold));

   // Entry update and result word.
   always_comb begin
      wr_last        = rd_last;
      wr_count       = rd_count;
      wr_flag        = rd_flag;
      wr_en          = 1'b0;
      cur_in         = cur_ff;
      rsp_channel_in = ech_ff;
      rsp_sample_in  = '0;
      rsp_count_in   = '0;
      rsp_changed_in = 1'b0;
      rsp_next_in    = CH_PORT_BITS'(cur_ff);
      if (cmd_ff == CMD_EDGE) begin
         if (ech_ok_ff) begin
            wr_count       = rd_count + COUNT_BITS'(1);
            wr_flag        = 1'b1;
            wr_en          = exec_go;
            rsp_count_in   = wr_count;
            rsp_changed_in = 1'b1;
         end
      end else begin
         if (do_count) begin
            wr_count = rd_count + COUNT_BITS'(1);
            wr_flag  = 1'b1;
         end
         if (sample_tracked) begin
            wr_last = smp_ff;
            wr_en   = exec_go;
         end
         if (exec_go) begin
            cur_in = scan_next;
         end
         rsp_channel_in = CH_PORT_BITS'(ch_ff);
         rsp_sample_in  = smp_ff;
         rsp_count_in   = wr_count;
         rsp_changed_in = wr_flag;
         rsp_next_in    = CH_PORT_BITS'(scan_next);
      end
   end

   // Output valid: loaded on update, cleared when taken.
   always_comb begin
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word capture and output payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         smp_ff    <= req_sample;
         ech_ff    <= req_edge_channel;
         ech_ok_ff <= ech_ok;
         ch_ff     <= rd_addr;
      end
      if (exec_go) begin
         rsp_channel_ff <= rsp_channel_in;
         rsp_sample_ff  <= rsp_sample_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_next_ff    <= rsp_next_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_pulse_count  = rsp_count_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_next_channel = rsp_next_ff;

   // The memory is never read and written in the same cycle.
   a_no_rw_overlap : assert property (@(posedge clock) disable iff (reset)
      !(accept && wr_en))
      else $error("state memory read and write overlap");

   // The scan position always names an existing channel.
   a_cur_in_range : assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < NUM_CHANNELS)
      else $error("current channel out of range");

   // A pending result that is stalled holds back the update of the next word.
   a_update_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && rsp_valid_ff && rsp_stall |=> (state_ff == ST_EXEC))
      else $error("update overran a stalled result");

   // Every accepted word leads to an update cycle.
   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted word not processed");

endmodule

FILE: hw/rtl/asp_csr.sv
// Configuration registers of the ADC scan pulse counter behind an APB-style port.
// Depends on asp_pkg for register indexes, widths and reset values.
module asp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [asp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [asp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [asp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready,
   output asp_pkg::cfg_type                  cfg
);
   import asp_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_strobe;

   // The port never inserts wait states.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign wr_strobe = psel && penable && pwrite && pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_index)
            REG_PULSE_MODE: cfg_in.pulse_mode_mask = pwdata[MASK_BITS-1:0];
            REG_DROP_THR:   cfg_in.drop_threshold  = pwdata[THR_BITS-1:0];
            REG_EDGE_BOUND: cfg_in.edge_counted_channels = pwdata[BOUND_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_mode_mask       <= MASK_RESET;
         cfg_ff.drop_threshold        <= THR_RESET;
         cfg_ff.edge_counted_channels <= BOUND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read decode.
   always_comb begin
      unique case (reg_index)
         REG_PULSE_MODE: prdata = CSR_DATA_BITS'(cfg_ff.pulse_mode_mask);
         REG_DROP_THR:   prdata = CSR_DATA_BITS'(cfg_ff.drop_threshold);
         REG_EDGE_BOUND: prdata = CSR_DATA_BITS'(cfg_ff.edge_counted_channels);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/asp_scan.sv
// Scan sequencer: picks the channel the mux selects after the given one.
// Depends on asp_pkg for the configuration struct.
module asp_scan #(
   parameter int NUM_CHANNELS = 22
) (
   input  asp_pkg::cfg_type                    cfg,
   input  logic [$clog2(NUM_CHANNELS)-1:0]     cur_channel,
   output logic [$clog2(NUM_CHANNELS)-1:0]     next_channel
);
   import asp_pkg::*;

   localparam int CH_W = $clog2(NUM_CHANNELS);

   logic [31:0]             mask_wide;
   logic [CH_W-1:0]         step_channel;
   logic [NUM_CHANNELS-1:0] stop_vec;

   assign mask_wide = 32'(cfg.pulse_mode_mask);

   // Plain increment with wrap at the channel count.
   always_comb begin
      if (32'(cur_channel) == NUM_CHANNELS - 1) begin
         step_channel = '0;
      end else begin
         step_channel = cur_channel + CH_W'(1);
      end
   end

   // A channel stops the scan if it is at or after the step position and is
   // either at/above the edge-counted boundary or not in pulse mode.
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         stop_vec[i] = (i >= int'(step_channel)) &&
                       ((i >= int'(cfg.edge_counted_channels)) || !mask_wide[i]);
      end
   end

   // Lowest stopping channel; none means the scan ran off the end and wraps.
   always_comb begin
      next_channel = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (stop_vec[i]) begin
            next_channel = CH_W'(i);
         end
      end
   end

endmodule

FILE: hw/rtl/asp_store.sv
// Per-channel state memory: last sample, pulse counter and changed flag.
// Synchronous, registered read; valid bits supply reset contents.
// Depends on asp_pkg.
module asp_store #(
   parameter int NUM_CHANNELS = 22,
   parameter int SAMPLE_BITS  = 12,
   parameter int COUNT_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [$clog2(NUM_CHANNELS)-1:0] rd_addr,
   output logic [SAMPLE_BITS-1:0]          rd_last,
   output logic [COUNT_BITS-1:0]           rd_count,
   output logic                            rd_flag,
   input  logic                            wr_en,
   input  logic [$clog2(NUM_CHANNELS)-1:0] wr_addr,
   input  logic [SAMPLE_BITS-1:0]          wr_last,
   input  logic [COUNT_BITS-1:0]           wr_count,
   input  logic                            wr_flag
);
   import asp_pkg::*;

   localparam int WORD_W = SAMPLE_BITS + COUNT_BITS + 1;

   logic [WORD_W-1:0]       mem [NUM_CHANNELS];
   logic [WORD_W-1:0]       rdata_ff;
   logic                    rvalid_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [NUM_CHANNELS-1:0] valid_in;

   // Memory array: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_flag, wr_count, wr_last};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // An entry becomes valid on its first write.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Unwritten entries read as the reset contents: full-scale sample, zero count.
   always_comb begin
      if (rvalid_ff) begin
         rd_last  = rdata_ff[SAMPLE_BITS-1:0];
         rd_count = rdata_ff[SAMPLE_BITS +: COUNT_BITS];
         rd_flag  = rdata_ff[WORD_W-1];
      end else begin
         rd_last  = '1;
         rd_count = '0;
         rd_flag  = 1'b0;
      end
   end

endmodule
